FILE: src/srt_pkg.sv
// shared types, codes and widths for the sorted record table
// no dependencies
package srt_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 16;
   localparam int POS_W  = 7;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;
   localparam int REC_W  = KEY_W + VAL_W;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic              load;
      logic              rd;
      logic              copy;
      logic              advance;
      logic              put_new;
      logic              fin;
      logic [STAT_W-1:0] fin_status;
      logic              fin_found;
   } srt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACT_W-1:0] op;
      logic             full;
      logic             bad_pos;
      logic             stop;
      logic             hit;
   } srt_stat_type;

endpackage

FILE: src/sorted_record_table_top.sv
// sorted record table: holds records in ascending key order
// depends on srt_pkg, srt_ctrl and srt_datapath
//
// usage
//   request: drive req_action, req_rec_key, req_rec_value and req_position and
//   raise start; the transaction is taken at a clock edge where start is high
//   and busy is low. busy stays high while the table walks its memory.
//   response: one result per transaction, shown for exactly one cycle with
//   rsp_valid high; the receiver has no way to hold it off.
// walk
//   each record takes a memory read, then a compare and shift: insert
//   moves down from the top, delete shifts the records above the gap, search scans up.
//   a compare can end the walk (search hit, insert slot above the bottom); rejected
//   transactions and no-ops finish without reading the memory.
//   the single record memory port pair, one read and one write a cycle, paces the walk.
//   start may be raised again in the cycle that rsp_valid shows.
// reset
//   synchronous reset empties the table; memory contents are not cleared and
//   need no clearing pass.
module sorted_record_table_top import srt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [KEY_W-1:0]  req_rec_key,
   input  logic [VAL_W-1:0]         req_rec_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic signed [KEY_W-1:0]  rsp_found_key,
   output logic [VAL_W-1:0]         rsp_found_value,
   output logic [POS_W-1:0]         rsp_entry_count
);

   srt_cmd_type  cmd;
   srt_stat_type stat;

   srt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   srt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_rec_key     (req_rec_key),
      .req_rec_value   (req_rec_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_key   (rsp_found_key),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

FILE: src/srt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/srt_ctrl.sv
// controller state machine for the sorted record table
// depends on srt_pkg
module srt_ctrl import srt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  srt_stat_type stat,
   output srt_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.op)
               ACT_INSERT: begin
                  if (stat.full) begin
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_FULL;
                  end else if (stat.stop) begin
                     cmd.put_new    = 1'b1;
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_OK;
                  end else begin
                     cmd.rd = 1'b1;
                  end
               end
               ACT_DELETE: begin
                  if (stat.bad_pos) begin
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_BADPOS;
                  end else if (stat.stop) begin
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_OK;
                  end else begin
                     cmd.rd = 1'b1;
                  end
               end
               ACT_SEARCH: begin
                  if (stat.stop) begin
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_NOTFOUND;
                  end else begin
                     cmd.rd = 1'b1;
                  end
               end
               default: begin
                  cmd.fin        = 1'b1;
                  cmd.fin_status = ST_OK;
               end
            endcase
            state_in = cmd.fin ? S_IDLE : S_EVAL;
         end
         S_EVAL: begin
            state_in = S_CHECK;
            case (stat.op)
               ACT_INSERT: begin
                  // shift the larger record up one slot, or drop the new one in the gap
                  if (stat.hit) begin
                     cmd.copy    = 1'b1;
                     cmd.advance = 1'b1;
                  end else begin
                     cmd.put_new    = 1'b1;
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_OK;
                     state_in       = S_IDLE;
                  end
               end
               ACT_DELETE: begin
                  cmd.copy    = 1'b1;
                  cmd.advance = 1'b1;
               end
               ACT_SEARCH: begin
                  if (stat.hit) begin
                     cmd.fin        = 1'b1;
                     cmd.fin_status = ST_OK;
                     cmd.fin_found  = 1'b1;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               default: begin
                  cmd.fin        = 1'b1;
                  cmd.fin_status = ST_OK;
                  state_in       = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.copy && cmd.put_new)) else $error("copy and new-record write together");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> !busy) else $error("still busy after finishing a transaction");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> (state_ff == S_EVAL) && !cmd.rd) else $error("read not followed by evaluate");

endmodule

FILE: src/srt_datapath.sv
// datapath: record memory, walk index, record count and result registers
// depends on srt_pkg and srt_ram
module srt_datapath import srt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srt_cmd_type              cmd,
   output srt_stat_type             stat,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [KEY_W-1:0]  req_rec_key,
   input  logic [VAL_W-1:0]         req_rec_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic signed [KEY_W-1:0]  rsp_found_key,
   output logic [VAL_W-1:0]         rsp_found_value,
   output logic [POS_W-1:0]         rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [ACT_W-1:0]        op_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0]        val_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic                    rsp_found_ff;
   logic signed [KEY_W-1:0] rsp_found_key_ff;
   logic [VAL_W-1:0]        rsp_found_value_ff;
   logic [POS_W-1:0]        rsp_entry_count_ff;

   logic [REC_W-1:0]        rd_data;
   logic signed [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0]        rd_val;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [REC_W-1:0]        wr_data;
   logic [PW-1:0]           pos_x;
   logic [PW-1:0]           count_x;
   logic                    ok_fin;

   assign rd_key  = rd_data[REC_W-1:VAL_W];
   assign rd_val  = rd_data[VAL_W-1:0];
   assign pos_x   = PW'(pos_ff);
   assign count_x = PW'(count_in);

   // walk direction: insert moves down from the top, delete and search move up
   always_comb begin
      case (op_ff)
         ACT_INSERT: rd_addr = AW'(idx_ff - CW'(1));
         ACT_DELETE: rd_addr = AW'(idx_ff + CW'(1));
         default:    rd_addr = AW'(idx_ff);
      endcase
   end

   assign wr_en   = cmd.copy | cmd.put_new;
   assign wr_data = cmd.put_new ? {key_ff, val_ff} : rd_data;

   srt_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(idx_ff)),
      .wr_data (wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.op      = op_ff;
      stat.full    = (count_ff >= CW'(CAPACITY));
      stat.bad_pos = (pos_ff == '0) || (pos_x > PW'(count_ff));
      case (op_ff)
         ACT_INSERT: stat.stop = (idx_ff == '0);
         ACT_DELETE: stat.stop = (({1'b0, idx_ff} + (CW+1)'(1)) >= {1'b0, count_ff});
         default:    stat.stop = (idx_ff >= count_ff);
      endcase
      if (op_ff == ACT_INSERT) begin
         stat.hit = (key_ff < rd_key);
      end else begin
         stat.hit = (rd_key == key_ff);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         case (req_action)
            ACT_INSERT: idx_in = count_ff;
            ACT_DELETE: idx_in = CW'(PW'(req_position) - PW'(1));
            default:    idx_in = '0;
         endcase
      end else if (cmd.advance) begin
         if (op_ff == ACT_INSERT) begin
            idx_in = idx_ff - CW'(1);
         end else begin
            idx_in = idx_ff + CW'(1);
         end
      end
   end

   assign ok_fin = cmd.fin && (cmd.fin_status == ST_OK);

   always_comb begin
      count_in = count_ff;
      if (ok_fin && op_ff == ACT_INSERT) begin
         count_in = count_ff + CW'(1);
      end else if (ok_fin && op_ff == ACT_DELETE) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.fin;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff  <= req_action;
         key_ff <= req_rec_key;
         val_ff <= req_rec_value;
         pos_ff <= req_position;
      end
      if (cmd.fin) begin
         rsp_status_ff      <= cmd.fin_status;
         rsp_found_ff       <= cmd.fin_found;
         rsp_found_key_ff   <= cmd.fin_found ? rd_key : '0;
         rsp_found_value_ff <= cmd.fin_found ? rd_val : '0;
         rsp_entry_count_ff <= count_x[POS_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_key   = rsp_found_key_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("record count above capacity");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe longer than one cycle");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK)
      else $error("found flagged with a failing status");

endmodule

FILE: test/tb_sorted_record_table_top.sv
// self-checking testbench for sorted_record_table_top: directed table, full-table fill, then
// random insert/delete/search traffic checked against an in-bench table model
// depends on srt_pkg and the sorted_record_table_top rtl
`timescale 1ns / 1ps

module tb_sorted_record_table_top;
   import srt_pkg::*;

   localparam int TABLE_DEPTH   = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int TAIL_CYCLES   = 2 + 2 * TABLE_DEPTH + 8;
   localparam int MAX_GAP       = 30;
   localparam int PHASE_ITEMS   = 180;
   localparam int BLOCK_ITEMS   = 45;
   localparam int REPORT_LIMIT  = 10;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic                     found;
      logic signed [KEY_W-1:0]  key;
      logic [VAL_W-1:0]         value;
      logic [POS_W-1:0]         count;
   } table_reply_type;

   typedef struct packed {
      logic [ACT_W-1:0]         act;
      logic signed [KEY_W-1:0]  key;
      logic [VAL_W-1:0]         val;
      logic [POS_W-1:0]         pos;
      logic                     typed;
      table_reply_type          reply;
   } stim_row_type;

   localparam table_reply_type NO_REPLY = '0;

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{ACT_SEARCH, 32'sd0,   16'h0000, 7'd0,   1'b1, '{ST_NOTFOUND, 1'b0, 32'sd0, 16'h0, 7'd0}},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd0,   1'b1, '{ST_BADPOS, 1'b0, 32'sd0, 16'h0, 7'd0}},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd1,   1'b1, '{ST_BADPOS, 1'b0, 32'sd0, 16'h0, 7'd0}},
      '{ACT_NOP,    -32'sd1,  16'hffff, 7'd127, 1'b1, '{ST_OK, 1'b0, 32'sd0, 16'h0, 7'd0}},
      '{ACT_INSERT, KEY_MIN,  16'h0000, 7'd0,   1'b1, '{ST_OK, 1'b0, 32'sd0, 16'h0, 7'd1}},
      '{ACT_INSERT, KEY_MAX,  16'hffff, 7'd127, 1'b1, '{ST_OK, 1'b0, 32'sd0, 16'h0, 7'd2}},
      '{ACT_SEARCH, KEY_MIN,  16'h0000, 7'd0,   1'b1, '{ST_OK, 1'b1, KEY_MIN, 16'h0000, 7'd2}},
      '{ACT_SEARCH, KEY_MAX,  16'h0000, 7'd0,   1'b1, '{ST_OK, 1'b1, KEY_MAX, 16'hffff, 7'd2}},
      '{ACT_INSERT, 32'sd0,   16'h0100, 7'd0,   1'b0, NO_REPLY},
      // equal key lands after the first one
      '{ACT_INSERT, 32'sd0,   16'h0280, 7'd0,   1'b0, NO_REPLY},
      '{ACT_INSERT, -32'sd1,  16'h8000, 7'd0,   1'b0, NO_REPLY},
      '{ACT_SEARCH, 32'sd0,   16'h0000, 7'd0,   1'b0, NO_REPLY},
      '{ACT_SEARCH, 32'sd5,   16'h0000, 7'd0,   1'b0, NO_REPLY},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd6,   1'b0, NO_REPLY},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd127, 1'b0, NO_REPLY},
      // last record, then first record
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd5,   1'b0, NO_REPLY},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd1,   1'b0, NO_REPLY},
      '{ACT_SEARCH, 32'sd0,   16'h0000, 7'd0,   1'b0, NO_REPLY},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd2,   1'b0, NO_REPLY},
      '{ACT_SEARCH, 32'sd0,   16'h0000, 7'd0,   1'b0, NO_REPLY},
      '{ACT_NOP,    32'sd7,   16'h1234, 7'd3,   1'b0, NO_REPLY},
      '{ACT_INSERT, 32'sd1,   16'hffff, 7'd0,   1'b0, NO_REPLY},
      '{ACT_DELETE, 32'sd0,   16'h0000, 7'd64,  1'b0, NO_REPLY}
   };

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ACT_W-1:0]        req_action;
   logic signed [KEY_W-1:0] req_rec_key;
   logic [VAL_W-1:0]        req_rec_value;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_valid;
   logic [STAT_W-1:0]       rsp_status;
   logic                    rsp_found;
   logic signed [KEY_W-1:0] rsp_found_key;
   logic [VAL_W-1:0]        rsp_found_value;
   logic [POS_W-1:0]        rsp_entry_count;

   // table model state
   logic signed [KEY_W-1:0] model_keys [TABLE_DEPTH];
   logic [VAL_W-1:0]        model_vals [TABLE_DEPTH];
   int                      model_count;

   table_reply_type         expected_replies [$];
   int                      mismatches;
   int                      idle_pct;
   int                      n_inserted, n_full, n_deleted, n_badpos, n_hits, n_misses, n_nops;
   int                      peak_count;

   sorted_record_table_top #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_rec_key     (req_rec_key),
      .req_rec_value   (req_rec_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_key   (rsp_found_key),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // applies one transaction to the table model and returns the reply it should give
   function automatic table_reply_type table_apply(input logic [ACT_W-1:0] act,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
      table_reply_type r;
      int              slot;
      r = '0;
      case (act)
         ACT_INSERT: begin
            if (model_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               slot = 0;
               while (slot < model_count && !(key < model_keys[slot])) slot++;
               for (int i = model_count; i > slot; i--) begin
                  model_keys[i] = model_keys[i-1];
                  model_vals[i] = model_vals[i-1];
               end
               model_keys[slot] = key;
               model_vals[slot] = val;
               model_count++;
               r.status = ST_OK;
               n_inserted++;
            end
         end
         ACT_DELETE: begin
            if (pos == 0 || int'(pos) > model_count) begin
               r.status = ST_BADPOS;
               n_badpos++;
            end else begin
               for (int i = int'(pos) - 1; i + 1 < model_count; i++) begin
                  model_keys[i] = model_keys[i+1];
                  model_vals[i] = model_vals[i+1];
               end
               model_count--;
               r.status = ST_OK;
               n_deleted++;
            end
         end
         ACT_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < model_count; i++) begin
               if (model_keys[i] == key) begin
                  r.status = ST_OK;
                  r.found  = 1'b1;
                  r.key    = model_keys[i];
                  r.value  = model_vals[i];
                  break;
               end
            end
            if (r.found) n_hits++;
            else n_misses++;
         end
         default: n_nops++;
      endcase
      r.count = model_count[POS_W-1:0];
      if (model_count > peak_count) peak_count = model_count;
      return r;
   endfunction

   // mostly keys already held or near zero so duplicates and hits are common
   function automatic logic signed [KEY_W-1:0] pick_key(input int hit_pct);
      if (model_count > 0 && $urandom_range(99) < hit_pct)
         return model_keys[$urandom_range(model_count - 1)];
      case ($urandom_range(9))
         0, 1, 2, 3: return KEY_W'(int'($urandom_range(16)) - 8);
         4, 5: begin
            case ($urandom_range(3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return VAL_W'($urandom_range(16'hffff));
      endcase
   endfunction

   // first and last record weighted up, a share of out-of-range positions
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      int top;
      r   = $urandom_range(99);
      top = (model_count > 0) ? model_count : 1;
      if (r < 20) return POS_W'(1);
      if (r < 35) return POS_W'(model_count);
      if (r < 75) return POS_W'($urandom_range(top, 1));
      if (r < 82) return '0;
      return POS_W'($urandom_range(127));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_txn(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos,
                           input logic typed, input table_reply_type typed_reply);
      table_reply_type predicted;
      int              gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         start         = 1'b0;
         req_action    = ACT_W'($urandom_range(3));
         req_rec_key   = $urandom;
         req_rec_value = VAL_W'($urandom_range(16'hffff));
         req_position  = POS_W'($urandom_range(127));
         @(negedge clock);
         gap++;
      end
      start         = 1'b1;
      req_action    = act;
      req_rec_key   = key;
      req_rec_value = val;
      req_position  = pos;
      do @(posedge clock); while (busy);
      predicted = table_apply(act, key, val, pos);
      expected_replies.push_back(typed ? typed_reply : predicted);
      @(negedge clock);
   endtask

   task automatic random_txn(input int ins_pct, input int del_pct);
      logic [ACT_W-1:0] act;
      int               roll;
      roll = $urandom_range(99);
      if (roll < ins_pct) act = ACT_INSERT;
      else if (roll < ins_pct + del_pct) act = ACT_DELETE;
      else if (roll < 97) act = ACT_SEARCH;
      else act = ACT_NOP;
      send_txn(act, pick_key(act == ACT_SEARCH ? 60 : 30), pick_value(), pick_position(),
               1'b0, NO_REPLY);
   endtask

   task automatic wait_for_replies();
      start = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin : check_replies
      table_reply_type seen;
      table_reply_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_status, rsp_found, rsp_found_key, rsp_found_value, rsp_entry_count};
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: status %0d found %0d key %0d value %h count %0d",
                        seen.status, seen.found, seen.key, seen.value, seen.count);
         end else begin
            want = expected_replies.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch (exp/got): status %0d/%0d found %0d/%0d key %0d/%0d",
                            " value %h/%h count %0d/%0d"},
                           want.status, seen.status, want.found, seen.found, want.key,
                           seen.key, want.value, seen.value, want.count, seen.count);
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      mismatches    = 0;
      model_count   = 0;
      peak_count    = 0;
      n_inserted    = 0;
      n_full        = 0;
      n_deleted     = 0;
      n_badpos      = 0;
      n_hits        = 0;
      n_misses      = 0;
      n_nops        = 0;
      idle_pct      = 33;
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = ACT_NOP;
      req_rec_key   = '0;
      req_rec_value = '0;
      req_position  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED_TABLE[r];
         send_txn(row.act, row.key, row.val, row.pos, row.typed, row.reply);
      end

      // fill to capacity, push past it, then trim both ends
      while (model_count < TABLE_DEPTH)
         send_txn(ACT_INSERT, pick_key(20), pick_value(), pick_position(), 1'b0, NO_REPLY);
      repeat (3)
         send_txn(ACT_INSERT, pick_key(20), pick_value(), pick_position(), 1'b0, NO_REPLY);
      send_txn(ACT_SEARCH, pick_key(100), pick_value(), pick_position(), 1'b0, NO_REPLY);
      send_txn(ACT_DELETE, pick_key(0), pick_value(), POS_W'(TABLE_DEPTH), 1'b0, NO_REPLY);
      send_txn(ACT_DELETE, pick_key(0), pick_value(), POS_W'(1), 1'b0, NO_REPLY);
      send_txn(ACT_INSERT, pick_key(20), pick_value(), pick_position(), 1'b0, NO_REPLY);
      wait_for_replies();

      // three phases: light sender gaps, heavy gaps, back to back
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((n / BLOCK_ITEMS) % 2 == 0) random_txn(70, 10);
            else random_txn(15, 60);
         end
         wait_for_replies();
      end

      start = 1'b0;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_replies.size() != 0) mismatches++;

      $display("covered: %0d inserts, %0d full rejects, %0d deletes, %0d bad positions",
               n_inserted, n_full, n_deleted, n_badpos);
      $display("covered: %0d search hits, %0d misses, %0d no-ops, peak fill %0d, %0d mismatches",
               n_hits, n_misses, n_nops, peak_count, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
